### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the reply loss tracker.
// Expects clk and rst_n in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define RLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold outside reset.
`define RLT_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

### rtl/rlt_pkg.sv
// Package of the reply loss tracker: sizes, types, codes and row helpers.
// No dependencies; used by reply_loss_tracker_nak_builder_core.
package rlt_pkg;

    localparam int SLOTS         = 512;
    localparam int MAX_OUT_BYTES = 64;
    localparam int SEQ_W         = 7;
    localparam int WRAP_W        = 3;
    localparam int ACK_SLOT_W    = SEQ_W + WRAP_W;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int ROW_BITS      = 16;
    localparam int BIT_W         = $clog2(ROW_BITS);
    localparam int ROWS          = SLOTS / ROW_BITS;
    localparam int ROW_W         = $clog2(ROWS);
    localparam int CNT_W         = SLOT_W + 1;
    localparam int LIMIT_W       = 4;
    localparam int BUDGET_W      = 7;
    localparam int BYTE_W        = 8;
    localparam int WRAP_MAX      = 7;
    localparam int LIST_MAX      = 15;
    localparam int ESC_LIMIT     = 254;
    localparam int ESC_BYTE      = 8'hff;
    localparam int RESET_LIMIT   = 10;
    localparam int RESET_BUDGET  = 64;

    typedef logic [SEQ_W-1:0]      seq_t;
    typedef logic [WRAP_W-1:0]     wrap_t;
    typedef logic [ACK_SLOT_W-1:0] ack_slot_t;
    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [BIT_W-1:0]      bit_idx_t;
    typedef logic [ROW_BITS-1:0]   row_bits_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [LIMIT_W-1:0]    lists_t;
    typedef logic [BUDGET_W-1:0]   budget_t;
    typedef logic [BYTE_W-1:0]     byte_t;
    typedef logic [BIT_W:0]        pop_t;

    typedef enum logic [1:0] {
        REQ_ACK   = 2'd0,
        REQ_FLUSH = 2'd1,
        REQ_RESET = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [0:0] {
        CFG_LIMIT  = 1'b0,
        CFG_BUDGET = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACK_WR,
        ST_CNT_RD,
        ST_CNT_ACC,
        ST_EM_CNT,
        ST_EM_RD,
        ST_EM_LOAD,
        ST_EM_IDX,
        ST_EM_ESC
    } state_t;

    function automatic pop_t popcount(input row_bits_t v);
        pop_t n;
        n = '0;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            n = n + pop_t'(v[b]);
        end
        return n;
    endfunction

    function automatic bit_idx_t lowest_set(input row_bits_t v);
        bit_idx_t idx;
        idx = '0;
        for (int b = ROW_BITS - 1; b >= 0; b--)
        begin
            if (v[b])
            begin
                idx = bit_idx_t'(b);
            end
        end
        return idx;
    endfunction

    // Slots of a row that lie at or below the top slot.
    function automatic row_bits_t row_mask(input row_t row, input row_t last_row,
                                           input bit_idx_t top_lo);
        row_bits_t m;
        for (int b = 0; b < ROW_BITS; b++)
        begin
            m[b] = (row < last_row) || (bit_idx_t'(b) <= top_lo);
        end
        return m;
    endfunction

endpackage

### rtl/rlt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rlt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/reply_loss_tracker_nak_builder_core.sv
// Reply loss tracker and NAK list builder, top level.
// Depends on rlt_pkg, rlt_ram and assert_macros.svh.
//
// Received slots are kept as a bitmap in a RAM of 32 rows of 16 bits. An ack
// is accepted with a row read and then writes the row back; an ack whose slot
// is out of range, a skipped flush and an unused request are only accepted. A
// flush is accepted, reads each row up to the top slot to count the missing
// slots and, if any is missing, emits the count byte, then reads, loads and
// indexes each row again and emits the bytes of each missing slot up to the
// byte budget (waiting while the output is stalled), then runs a clearing
// pass over the bitmap RAM. After reset and after a session reset the same
// clearing pass runs before the first item is taken. Configuration writes are
// taken at any time; the byte budget is latched when a flush starts.
module reply_loss_tracker_nak_builder_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_addr,
    input  logic [6:0] cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [6:0] seq
    input  logic [1:0] s_axis_tuser,   // [1:0] req_type
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] nak_byte
    output logic [0:0] m_axis_tuser,   // [0] is_count
    output logic       m_axis_tlast
);

    `include "assert_macros.svh"

    rlt_pkg::state_t    state_reg, state_next;
    rlt_pkg::lists_t    limit_reg, limit_next;
    rlt_pkg::budget_t   budget_reg, budget_next;
    rlt_pkg::slot_t     top_reg, top_next;
    rlt_pkg::wrap_t     wrap_reg, wrap_next;
    rlt_pkg::seq_t      last_seq_reg, last_seq_next;
    rlt_pkg::lists_t    lists_reg, lists_next;
    rlt_pkg::row_t      row_reg, row_next;
    rlt_pkg::cnt_t      missing_reg, missing_next;
    rlt_pkg::budget_t   n_reg, n_next;
    rlt_pkg::budget_t   budget_eff_reg, budget_eff_next;
    logic               out_valid_reg, out_valid_next;

    rlt_pkg::row_t      ack_row_reg, ack_row_next;
    rlt_pkg::bit_idx_t  ack_bit_reg, ack_bit_next;
    rlt_pkg::seq_t      flush_seq_reg, flush_seq_next;
    rlt_pkg::row_bits_t mask_reg, mask_next;
    rlt_pkg::bit_idx_t  sel_bit_reg, sel_bit_next;
    rlt_pkg::slot_t     v_reg, v_next;
    rlt_pkg::byte_t     out_byte_reg, out_byte_next;
    logic               out_cnt_reg, out_cnt_next;
    logic               out_last_reg, out_last_next;

    logic               ram_we;
    rlt_pkg::row_t      ram_waddr;
    rlt_pkg::row_bits_t ram_wdata;
    rlt_pkg::row_t      ram_raddr;
    rlt_pkg::row_bits_t ram_rdata;

    rlt_pkg::req_t      req;
    rlt_pkg::seq_t      seq;
    rlt_pkg::wrap_t     ack_wrap;
    rlt_pkg::ack_slot_t ack_slot;
    rlt_pkg::slot_t     ack_slot_t;
    logic               ack_in_range;
    rlt_pkg::row_t      last_row;
    rlt_pkg::row_bits_t cur_mask;
    rlt_pkg::cnt_t      missing_sum;
    rlt_pkg::budget_t   n_inc;
    logic               out_free;
    logic               finish;
    logic               is_last;

    rlt_ram #(
        .WIDTH(rlt_pkg::ROW_BITS),
        .DEPTH(rlt_pkg::ROWS)
    ) u_bitmap (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req      = rlt_pkg::req_t'(s_axis_tuser);
    assign seq      = s_axis_tdata[rlt_pkg::SEQ_W-1:0];
    assign ack_wrap = (seq < last_seq_reg && wrap_reg < rlt_pkg::WRAP_MAX) ?
                      rlt_pkg::wrap_t'(wrap_reg + 1'b1) : wrap_reg;
    assign ack_slot     = {ack_wrap, seq};
    assign ack_in_range = ack_slot < rlt_pkg::SLOTS;
    assign ack_slot_t   = rlt_pkg::slot_t'(ack_slot);

    assign last_row    = top_reg[rlt_pkg::SLOT_W-1:rlt_pkg::BIT_W];
    assign cur_mask    = rlt_pkg::row_mask(row_reg, last_row,
                                           top_reg[rlt_pkg::BIT_W-1:0]);
    assign missing_sum = missing_reg + rlt_pkg::cnt_t'(rlt_pkg::popcount(~ram_rdata & cur_mask));
    assign n_inc       = rlt_pkg::budget_t'(n_reg + 1'b1);
    assign out_free    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        budget_next     = budget_reg;
        top_next        = top_reg;
        wrap_next       = wrap_reg;
        last_seq_next   = last_seq_reg;
        lists_next      = lists_reg;
        row_next        = row_reg;
        missing_next    = missing_reg;
        n_next          = n_reg;
        budget_eff_next = budget_eff_reg;
        ack_row_next    = ack_row_reg;
        ack_bit_next    = ack_bit_reg;
        flush_seq_next  = flush_seq_reg;
        mask_next       = mask_reg;
        sel_bit_next    = sel_bit_reg;
        v_next          = v_reg;
        out_byte_next   = out_byte_reg;
        out_cnt_next    = out_cnt_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        ram_we          = 1'b0;
        ram_waddr       = row_reg;
        ram_wdata       = '0;
        ram_raddr       = row_reg;
        s_axis_tready   = 1'b0;
        finish          = 1'b0;
        is_last         = 1'b0;

        if (cfg_we)
        begin
            unique case (rlt_pkg::cfg_idx_t'(cfg_addr))
                rlt_pkg::CFG_LIMIT:  limit_next  = cfg_wdata[rlt_pkg::LIMIT_W-1:0];
                rlt_pkg::CFG_BUDGET: budget_next = cfg_wdata[rlt_pkg::BUDGET_W-1:0];
            endcase
        end

        unique case (state_reg)
            rlt_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                row_next = rlt_pkg::row_t'(row_reg + 1'b1);
                if (row_reg == rlt_pkg::row_t'(rlt_pkg::ROWS - 1))
                begin
                    state_next = rlt_pkg::ST_IDLE;
                end
            end
            rlt_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                ram_raddr     = ack_slot_t[rlt_pkg::SLOT_W-1:rlt_pkg::BIT_W];
                if (s_axis_tvalid)
                begin
                    case (req)
                        rlt_pkg::REQ_ACK:
                        begin
                            wrap_next     = ack_wrap;
                            last_seq_next = seq;
                            if (ack_in_range)
                            begin
                                ack_row_next = ack_slot_t[rlt_pkg::SLOT_W-1:rlt_pkg::BIT_W];
                                ack_bit_next = ack_slot_t[rlt_pkg::BIT_W-1:0];
                                if (ack_slot_t > top_reg)
                                begin
                                    top_next = ack_slot_t;
                                end
                                state_next = rlt_pkg::ST_ACK_WR;
                            end
                        end
                        rlt_pkg::REQ_FLUSH:
                        begin
                            if (top_reg != '0 && lists_reg <= limit_reg)
                            begin
                                if (lists_reg != rlt_pkg::lists_t'(rlt_pkg::LIST_MAX))
                                begin
                                    lists_next = rlt_pkg::lists_t'(lists_reg + 1'b1);
                                end
                                if (budget_reg == '0)
                                begin
                                    budget_eff_next = rlt_pkg::budget_t'(1);
                                end
                                else if (budget_reg > rlt_pkg::MAX_OUT_BYTES)
                                begin
                                    budget_eff_next = rlt_pkg::budget_t'(rlt_pkg::MAX_OUT_BYTES);
                                end
                                else
                                begin
                                    budget_eff_next = budget_reg;
                                end
                                flush_seq_next = seq;
                                missing_next   = '0;
                                n_next         = '0;
                                row_next       = '0;
                                state_next     = rlt_pkg::ST_CNT_RD;
                            end
                        end
                        rlt_pkg::REQ_RESET:
                        begin
                            top_next      = '0;
                            wrap_next     = '0;
                            last_seq_next = '0;
                            lists_next    = '0;
                            row_next      = '0;
                            state_next    = rlt_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            rlt_pkg::ST_ACK_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ack_row_reg;
                ram_wdata  = ram_rdata | (rlt_pkg::row_bits_t'(1) << ack_bit_reg);
                state_next = rlt_pkg::ST_IDLE;
            end
            rlt_pkg::ST_CNT_RD:
            begin
                state_next = rlt_pkg::ST_CNT_ACC;
            end
            rlt_pkg::ST_CNT_ACC:
            begin
                missing_next = missing_sum;
                if (row_reg == last_row)
                begin
                    row_next = '0;
                    if (missing_sum != '0)
                    begin
                        state_next = rlt_pkg::ST_EM_CNT;
                    end
                    else
                    begin
                        finish = 1'b1;
                    end
                end
                else
                begin
                    row_next   = rlt_pkg::row_t'(row_reg + 1'b1);
                    state_next = rlt_pkg::ST_CNT_RD;
                end
            end
            rlt_pkg::ST_EM_CNT:
            begin
                if (out_free)
                begin
                    is_last        = (n_inc == budget_eff_reg);
                    out_valid_next = 1'b1;
                    out_byte_next  = missing_reg[rlt_pkg::BYTE_W-1:0];
                    out_cnt_next   = 1'b1;
                    out_last_next  = is_last;
                    n_next         = n_inc;
                    if (is_last)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        state_next = rlt_pkg::ST_EM_RD;
                    end
                end
            end
            rlt_pkg::ST_EM_RD:
            begin
                state_next = rlt_pkg::ST_EM_LOAD;
            end
            rlt_pkg::ST_EM_LOAD:
            begin
                mask_next  = ~ram_rdata & cur_mask;
                state_next = rlt_pkg::ST_EM_IDX;
            end
            rlt_pkg::ST_EM_IDX:
            begin
                if (mask_reg == '0)
                begin
                    if (row_reg == last_row)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        row_next   = rlt_pkg::row_t'(row_reg + 1'b1);
                        state_next = rlt_pkg::ST_EM_RD;
                    end
                end
                else
                begin
                    sel_bit_next = rlt_pkg::lowest_set(mask_reg);
                    v_next       = {row_reg, rlt_pkg::lowest_set(mask_reg)};
                    state_next   = rlt_pkg::ST_EM_ESC;
                end
            end
            rlt_pkg::ST_EM_ESC:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_cnt_next   = 1'b0;
                    n_next         = n_inc;
                    if (v_reg > rlt_pkg::ESC_LIMIT)
                    begin
                        is_last       = (n_inc == budget_eff_reg);
                        out_byte_next = rlt_pkg::byte_t'(rlt_pkg::ESC_BYTE);
                        v_next        = rlt_pkg::slot_t'(v_reg - rlt_pkg::ESC_LIMIT);
                    end
                    else
                    begin
                        is_last       = (n_inc == budget_eff_reg) ||
                                        (missing_reg == rlt_pkg::cnt_t'(1));
                        out_byte_next = rlt_pkg::byte_t'(v_reg);
                        missing_next  = rlt_pkg::cnt_t'(missing_reg - 1'b1);
                        mask_next     = mask_reg & ~(rlt_pkg::row_bits_t'(1) << sel_bit_reg);
                        state_next    = rlt_pkg::ST_EM_IDX;
                    end
                    out_last_next = is_last;
                    if (is_last)
                    begin
                        finish = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = rlt_pkg::ST_CLEAR;
                row_next   = '0;
            end
        endcase

        if (finish)
        begin
            top_next      = rlt_pkg::slot_t'(flush_seq_reg);
            wrap_next     = '0;
            last_seq_next = '0;
            row_next      = '0;
            state_next    = rlt_pkg::ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rlt_pkg::ST_CLEAR;
            limit_reg      <= rlt_pkg::lists_t'(rlt_pkg::RESET_LIMIT);
            budget_reg     <= rlt_pkg::budget_t'(rlt_pkg::RESET_BUDGET);
            top_reg        <= '0;
            wrap_reg       <= '0;
            last_seq_reg   <= '0;
            lists_reg      <= '0;
            row_reg        <= '0;
            missing_reg    <= '0;
            n_reg          <= '0;
            budget_eff_reg <= rlt_pkg::budget_t'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            budget_reg     <= budget_next;
            top_reg        <= top_next;
            wrap_reg       <= wrap_next;
            last_seq_reg   <= last_seq_next;
            lists_reg      <= lists_next;
            row_reg        <= row_next;
            missing_reg    <= missing_next;
            n_reg          <= n_next;
            budget_eff_reg <= budget_eff_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ack_row_reg   <= ack_row_next;
        ack_bit_reg   <= ack_bit_next;
        flush_seq_reg <= flush_seq_next;
        mask_reg      <= mask_next;
        sel_bit_reg   <= sel_bit_next;
        v_reg         <= v_next;
        out_byte_reg  <= out_byte_next;
        out_cnt_reg   <= out_cnt_next;
        out_last_reg  <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_cnt_reg;
    assign m_axis_tlast  = out_last_reg;

    // a waiting item stays on the output until it is taken
    `RLT_ASSERT(a_out_held, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "item changed while waiting")
    `RLT_ASSERT(a_budget_kept, m_axis_tvalid |-> n_reg <= budget_eff_reg, "byte budget exceeded")
    `RLT_ASSERT_NEVER(a_index_without_missing, state_reg == rlt_pkg::ST_EM_ESC && missing_reg == '0, "index emitted with no missing slot left")

endmodule

### test/reply_loss_tracker_nak_builder_core_test.sv
// Testbench for reply_loss_tracker_nak_builder_core: drives acks, flushes and session
// resets, predicts each NAK list byte and checks the output stream in order.
// Depends on rlt_pkg and the RTL of the block.
module reply_loss_tracker_nak_builder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rlt_pkg::*;

    localparam int HOLD_OFF_CYCLES = 500;
    localparam int SETTLE_CYCLES   = 400;
    localparam int LIMIT_CYCLES    = 3000000;

    typedef struct packed {
        byte_t value;
        logic  count_flag;
        logic  tail;
    } nak_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [0:0] cfg_addr = CFG_LIMIT;
    logic [6:0] cfg_wdata = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;      // [6:0] seq
    logic [1:0] s_axis_tuser = REQ_ACK; // [1:0] req_type
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] nak_byte
    logic [0:0] m_axis_tuser;           // [0] is_count
    logic       m_axis_tlast;

    // predicted block state
    logic [SLOTS-1:0] got_map = '0;
    slot_t            top_seen = '0;
    wrap_t            wrap_seen = '0;
    seq_t             prev_seq = '0;
    lists_t           lists_done = '0;
    lists_t           list_limit = lists_t'(RESET_LIMIT);
    budget_t          byte_budget = budget_t'(RESET_BUDGET);

    nak_t pending_nak_bytes[$];
    int   errors = 0;
    bit   steady = 1'b0;
    bit   hold_off_req = 1'b0;
    seq_t stream_seq = '0;

    reply_loss_tracker_nak_builder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 24);
    endfunction

    function automatic void queue_nak(byte_t b, logic is_cnt);
        pending_nak_bytes.push_back({b, is_cnt, 1'b0});
    endfunction

    function automatic void clear_session();
        got_map = '0;
        top_seen = '0;
        wrap_seen = '0;
        prev_seq = '0;
        lists_done = '0;
    endfunction

    function automatic void track_ack(seq_t s);
        int slot;
        if (s < prev_seq && wrap_seen < WRAP_MAX)
            wrap_seen++;
        prev_seq = s;
        slot = int'(s) + int'(wrap_seen) * (1 << SEQ_W);
        if (slot < SLOTS)
        begin
            got_map[slot] = 1'b1;
            if (slot > int'(top_seen))
                top_seen = slot_t'(slot);
        end
    endfunction

    function automatic void build_nak_list(seq_t new_top);
        int   cap;
        int   missing;
        int   n;
        int   v;
        nak_t item;
        if (top_seen == '0 || lists_done > list_limit)
            return;
        if (lists_done < LIST_MAX)
            lists_done++;
        cap = int'(byte_budget);
        if (cap < 1)
            cap = 1;
        if (cap > MAX_OUT_BYTES)
            cap = MAX_OUT_BYTES;
        missing = 0;
        for (int i = 0; i <= int'(top_seen); i++)
        begin
            if (!got_map[i])
                missing++;
        end
        if (missing != 0)
        begin
            queue_nak(byte_t'(missing), 1'b1);
            n = 1;
            for (int i = 0; i <= int'(top_seen) && n < cap; i++)
            begin
                if (!got_map[i])
                begin
                    v = i;
                    // indices past the escape limit go out as 0xff steps
                    while (v > ESC_LIMIT && n < cap)
                    begin
                        queue_nak(byte_t'(ESC_BYTE), 1'b0);
                        n++;
                        v -= ESC_LIMIT;
                    end
                    if (n < cap)
                    begin
                        queue_nak(byte_t'(v), 1'b0);
                        n++;
                    end
                end
            end
            item = pending_nak_bytes.pop_back();
            item.tail = 1'b1;
            pending_nak_bytes.push_back(item);
        end
        got_map = '0;
        top_seen = slot_t'(new_top);
        wrap_seen = '0;
        prev_seq = '0;
    endfunction

    function automatic void predict_request(req_t req, seq_t s);
        case (req)
            REQ_ACK:   track_ack(s);
            REQ_FLUSH: build_nak_list(s);
            REQ_RESET: clear_session();
            default:   ;
        endcase
    endfunction

    task automatic offer_request(req_t req, seq_t s);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {1'b0, s};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_request(req, s);
        gap = pick_gap();
        if (gap != 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_for_quiet();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_nak_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [6:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LIMIT)
            list_limit = val[3:0];
        else
            byte_budget = val;
    endtask

    // Bursts of mostly in-order acks with losses, each usually closed by a flush,
    // mixed with session resets and random noise items.
    task automatic random_phase(int n_items, int max_burst, int long_len, int reset_pct);
        int   count;
        int   r;
        int   len;
        int   jitter;
        req_t req;
        count = 0;
        while (count < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
                steady = !steady;
            r = $urandom_range(0, 99);
            if (r < 6)
            begin
                req = req_t'($urandom_range(0, 3));
                offer_request(req, seq_t'($urandom_range(0, 127)));
                if (req != REQ_NONE)
                    count++;
            end
            else if (r < 6 + reset_pct)
            begin
                offer_request(REQ_RESET, seq_t'($urandom_range(0, 127)));
                stream_seq = '0;
                count++;
            end
            else
            begin
                len = (long_len != 0) ? long_len : $urandom_range(0, max_burst);
                jitter = (long_len != 0) ? 0 : 3;
                long_len = 0;
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 84)
                        stream_seq += 1;
                    else if (r < 94)
                        stream_seq += seq_t'($urandom_range(2, 4));
                    else if (r >= 100 - jitter)
                        stream_seq -= seq_t'($urandom_range(1, 5));
                    offer_request(REQ_ACK, stream_seq);
                end
                count += len;
                if ($urandom_range(0, 4) != 0)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 60)
                        offer_request(REQ_FLUSH, seq_t'(stream_seq + 1));
                    else if (r < 80)
                        offer_request(REQ_FLUSH, seq_t'(127));
                    else
                        offer_request(REQ_FLUSH, seq_t'($urandom_range(0, 127)));
                    count++;
                end
            end
        end
    endtask

    task automatic test_directed();
        offer_request(REQ_FLUSH, 7'd5);     // top zero: skipped
        offer_request(REQ_NONE, 7'd127);    // unused request
        offer_request(REQ_ACK, 7'd127);
        offer_request(REQ_ACK, 7'd0);       // wrap
        offer_request(REQ_ACK, 7'd127);
        offer_request(REQ_ACK, 7'd0);
        offer_request(REQ_ACK, 7'd127);
        offer_request(REQ_ACK, 7'd0);
        offer_request(REQ_ACK, 7'd127);     // slot 511
        offer_request(REQ_ACK, 7'd100);     // slot out of range from here on
        offer_request(REQ_ACK, 7'd50);
        offer_request(REQ_ACK, 7'd20);
        offer_request(REQ_ACK, 7'd10);      // wrap count at max
        offer_request(REQ_ACK, 7'd0);       // wrap saturates
        offer_request(REQ_FLUSH, 7'd127);   // count wraps mod 256, budget cut
        offer_request(REQ_FLUSH, 7'd0);
        offer_request(REQ_FLUSH, 7'd3);     // top zero again: skipped
        offer_request(REQ_RESET, 7'd0);
        offer_request(REQ_ACK, 7'd0);
        offer_request(REQ_ACK, 7'd1);
        offer_request(REQ_FLUSH, 7'd2);     // nothing missing
        offer_request(REQ_ACK, 7'd1);
        offer_request(REQ_FLUSH, 7'd0);
    endtask

    task automatic test_backpressure();
        wait_for_quiet();
        offer_request(REQ_RESET, 7'd0);
        hold_off_req = 1'b1;
        offer_request(REQ_ACK, 7'd127);
        repeat (4) offer_request(REQ_FLUSH, 7'd127);
        offer_request(REQ_ACK, 7'd9);
    endtask

    task automatic test_escape_runs();
        wait_for_quiet();
        write_register(CFG_LIMIT, 7'h7f);
        write_register(CFG_BUDGET, 7'd127);
        offer_request(REQ_RESET, 7'd0);
        stream_seq = '0;
        random_phase(150, 30, 260, 3);
    endtask

    task automatic test_list_saturation();
        wait_for_quiet();
        write_register(CFG_BUDGET, 7'd0);
        random_phase(40, 1, 0, 0);
    endtask

    task automatic test_list_limit();
        wait_for_quiet();
        write_register(CFG_LIMIT, 7'd14);
        write_register(CFG_BUDGET, 7'd64);
        random_phase(20, 8, 0, 8);
    endtask

    task automatic test_tight_budget();
        wait_for_quiet();
        write_register(CFG_LIMIT, 7'd0);
        write_register(CFG_BUDGET, 7'd1);
        random_phase(20, 8, 0, 15);
    endtask

    task automatic test_random_config();
        repeat (3)
        begin
            wait_for_quiet();
            write_register(CFG_LIMIT, 7'($urandom_range(0, 15)));
            write_register(CFG_BUDGET, 7'($urandom_range(0, 127)));
            random_phase(10, 8, 0, 6);
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_escape_runs();
        test_list_saturation();
        test_list_limit();
        test_tight_budget();
        test_random_config();
        steady = 1'b0;
        wait_for_quiet();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : receiver
        int stall;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            stall = pick_gap();
            if (stall == 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : check_nak_bytes
        nak_t got;
        nak_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tdata, m_axis_tuser[0], m_axis_tlast};
            if (pending_nak_bytes.size() == 0)
                report($sformatf("unexpected nak byte %02h", got.value));
            else
            begin
                want = pending_nak_bytes.pop_front();
                if (got.value !== want.value)
                    report($sformatf("nak_byte %02h, expected %02h", got.value, want.value));
                if (got.count_flag !== want.count_flag)
                    report($sformatf("is_count %b, expected %b (byte %02h)",
                                     got.count_flag, want.count_flag, want.value));
                if (got.tail !== want.tail)
                    report($sformatf("tlast %b, expected %b (byte %02h)",
                                     got.tail, want.tail, want.value));
            end
        end
    end

    initial
    begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
